// ----- rtl/core/rnc_pkg.sv -----
// Package for the radius neighbor count unit: sizes, command codes, operation
// and sequencer state types, and the queue entry passed from front to back.
// No dependencies; every other file but rnc_ram imports it.
package rnc_pkg;

  // Store and coordinate sizes
  localparam int MAX_PARTICLES = 1024;
  localparam int COORD_BITS    = 24;
  localparam int ADDR_W        = $clog2(MAX_PARTICLES);
  localparam int COUNT_W       = $clog2(MAX_PARTICLES + 1);

  // Distance arithmetic widths
  localparam int DIFF_W   = COORD_BITS + 1;
  localparam int SQ_W     = 2 * DIFF_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int RADIUS_W = 51;

  // Input command field
  localparam int CMD_W = 2;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 4;
  localparam logic [CFG_ADDR_W-1:0] REG_RADIUS_ADDR = 4'd0;

  // Queue between front and back
  localparam int Q_DEPTH  = 2;
  localparam int Q_PTR_W  = $clog2(Q_DEPTH);
  localparam int Q_FILL_W = $clog2(Q_DEPTH + 1);

  // Classified operation
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_QUERY,
    OP_CLEAR,
    OP_NOP
  } op_t;

  // One queued item
  typedef struct packed {
    op_t                    op;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [COORD_BITS-1:0]  z;
  } q_item_t;

  // Back-end sequencer state
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN
  } back_state_t;

endpackage

// ----- rtl/core/rnc_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module rnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

// ----- rtl/core/rnc_front.sv -----
// Front end: accepts command items, classifies the command code and holds the
// items in a two-entry queue for the back end. Depends on rnc_pkg.
module rnc_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [rnc_pkg::CMD_W-1:0]      in_command,
  input  logic [rnc_pkg::COORD_BITS-1:0] in_coord_x,
  input  logic [rnc_pkg::COORD_BITS-1:0] in_coord_y,
  input  logic [rnc_pkg::COORD_BITS-1:0] in_coord_z,
  output logic                          q_valid,
  output rnc_pkg::q_item_t              q_item,
  input  logic                          q_pop
);
  import rnc_pkg::*;

  q_item_t              q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_FILL_W-1:0]  fill_r;
  logic                 push;
  op_t                  op;

  // Map the command code onto an operation; the unused code does nothing.
  always_comb begin
    unique case (in_command)
      CMD_LOAD:  op = OP_LOAD;
      CMD_QUERY: op = OP_QUERY;
      CMD_CLEAR: op = OP_CLEAR;
      default:   op = OP_NOP;
    endcase
  end

  assign busy    = (fill_r == Q_FILL_W'(Q_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (fill_r != '0);
  assign q_item  = q_r[rd_ptr_r];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{op: op, x: in_coord_x, y: in_coord_y, z: in_coord_z};
    end
  end

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      fill_r <= fill_r + Q_FILL_W'(push) - Q_FILL_W'(q_pop);
    end
  end

endmodule

// ----- rtl/core/rnc_back.sv -----
// Back end: executes queued operations against the particle store and runs the
// pipelined distance scan for queries. Depends on rnc_pkg and rnc_ram.
module rnc_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  rnc_pkg::q_item_t              q_item,
  output logic                          q_pop,
  input  logic [rnc_pkg::RADIUS_W-1:0]   radius_squared,
  output logic                          out_valid,
  output logic [rnc_pkg::COUNT_W-1:0]    out_neighbor_count,
  output logic                          out_status
);
  import rnc_pkg::*;

  localparam int ENTRY_W = 3 * COORD_BITS;

  back_state_t state_r, state_nxt;

  logic [COUNT_W-1:0]    count_r;
  logic [ADDR_W-1:0]     scan_r;
  logic [COUNT_W-1:0]    hits_r;
  logic [COORD_BITS-1:0] node_x_r, node_y_r, node_z_r;

  // Pipeline registers of the distance test
  logic                  rdv_r, dv_r, sqv_r, sumv_r;
  logic [DIFF_W-1:0]     ad_x_r, ad_y_r, ad_z_r;
  logic [SQ_W-1:0]       sq_x_r, sq_y_r, sq_z_r;
  logic [SUM_W-1:0]      sum_r;

  // Control from the sequencer
  logic                  wr_en, rd_en, start_query, clr, pipe_empty, last_addr, full;
  logic                  res_valid, res_status;
  logic [COUNT_W-1:0]    res_count;
  logic [ENTRY_W-1:0]    rd_data;
  logic [COORD_BITS-1:0] p_x, p_y, p_z;
  logic [DIFF_W-1:0]     d_x, d_y, d_z;

  assign full       = (count_r == COUNT_W'(MAX_PARTICLES));
  assign pipe_empty = !(rdv_r || dv_r || sqv_r || sumv_r);
  assign last_addr  = (scan_r == ADDR_W'(count_r - 1'b1));

  // Particle store: x, y and z side by side in one word
  rnc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_PARTICLES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[ADDR_W-1:0]),
    .wr_data ({q_item.x, q_item.y, q_item.z}),
    .rd_en   (rd_en),
    .rd_addr (scan_r),
    .rd_data (rd_data)
  );

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && q_item.op == OP_QUERY && count_r != '0) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last_addr) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop       = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    start_query = 1'b0;
    clr         = 1'b0;
    res_valid   = 1'b0;
    res_status  = 1'b0;
    res_count   = count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          unique case (q_item.op)
            OP_LOAD: begin
              res_valid = 1'b1;
              if (full) begin
                res_status = 1'b1;
              end else begin
                wr_en     = 1'b1;
                res_count = count_r + 1'b1;
              end
            end
            OP_QUERY: begin
              if (count_r == '0) begin
                res_valid = 1'b1;
                res_count = '0;
              end else begin
                start_query = 1'b1;
              end
            end
            OP_CLEAR: begin
              clr       = 1'b1;
              res_valid = 1'b1;
              res_count = '0;
            end
            OP_NOP: begin
              res_valid = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        rd_en = 1'b1;
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          res_valid = 1'b1;
          res_count = hits_r;
        end
      end
      default: ;
    endcase
  end

  // Sequencer, store fill level and scan address
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      scan_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr) begin
        count_r <= '0;
      end else if (wr_en) begin
        count_r <= count_r + 1'b1;
      end
      if (start_query) begin
        scan_r <= '0;
      end else if (rd_en) begin
        scan_r <= scan_r + 1'b1;
      end
    end
  end

  // Node position of the running query
  always_ff @(posedge clk) begin
    if (start_query) begin
      node_x_r <= q_item.x;
      node_y_r <= q_item.y;
      node_z_r <= q_item.z;
    end
  end

  // Signed coordinate differences, one particle per cycle
  assign {p_x, p_y, p_z} = rd_data;
  assign d_x = DIFF_W'(signed'(p_x)) - DIFF_W'(signed'(node_x_r));
  assign d_y = DIFF_W'(signed'(p_y)) - DIFF_W'(signed'(node_y_r));
  assign d_z = DIFF_W'(signed'(p_z)) - DIFF_W'(signed'(node_z_r));

  // Pipeline valid bits and hit counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rdv_r  <= 1'b0;
      dv_r   <= 1'b0;
      sqv_r  <= 1'b0;
      sumv_r <= 1'b0;
      hits_r <= '0;
    end else begin
      rdv_r  <= rd_en;
      dv_r   <= rdv_r;
      sqv_r  <= dv_r;
      sumv_r <= sqv_r;
      if (start_query) begin
        hits_r <= '0;
      end else if (sumv_r && (sum_r < SUM_W'(radius_squared))) begin
        hits_r <= hits_r + 1'b1;
      end
    end
  end

  // Datapath: difference, square, sum
  always_ff @(posedge clk) begin
    ad_x_r <= d_x[DIFF_W-1] ? -d_x : d_x;
    ad_y_r <= d_y[DIFF_W-1] ? -d_y : d_y;
    ad_z_r <= d_z[DIFF_W-1] ? -d_z : d_z;
    sq_x_r <= SQ_W'(ad_x_r) * SQ_W'(ad_x_r);
    sq_y_r <= SQ_W'(ad_y_r) * SQ_W'(ad_y_r);
    sq_z_r <= SQ_W'(ad_z_r) * SQ_W'(ad_z_r);
    sum_r  <= SUM_W'(sq_x_r) + SUM_W'(sq_y_r) + SUM_W'(sq_z_r);
  end

  // Result register: one strobe per completed operation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_neighbor_count <= res_count;
      out_status         <= res_status;
    end
  end

  // The store never holds more than its depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(MAX_PARTICLES))
    else $error("stored particle count exceeds store depth");

  // A query never finds more neighbors than particles stored.
  a_hits_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (hits_r <= count_r))
    else $error("hit count exceeds stored count");

  // The scan leaves no particle in flight when the query result is given.
  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN && state_nxt == ST_IDLE) |-> pipe_empty)
    else $error("query result issued with distance tests in flight");

  // No new item is taken from the queue while a scan is running.
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !q_pop)
    else $error("queue popped during a query scan");

endmodule

// ----- rtl/core/radius_neighbor_count_unit.sv -----
// Top level of the radius neighbor count unit: configuration register file,
// front end with its queue, and back end with the particle store.
// Depends on rnc_pkg, rnc_front, rnc_back and rnc_ram.
//
//  Channel   Handshake                 Payload
//  input     start / busy              in_command, in_coord_x/y/z
//  result    out_valid strobe          out_neighbor_count, out_status
//  config    APB psel/penable/pready   paddr, pwdata, prdata (radius_squared)
//
// Load, clear and no-op commands finish in the cycle the back end takes them;
// the result strobe follows in the next cycle. A query over N stored
// particles holds the back end while it takes the query, scans the store's
// single read port one particle a cycle, and drains the four-stage distance
// pipeline. Items queue two deep in front of the back end; busy rises only
// when that queue is full. Reset is synchronous and needs no clearing pass.
// The result receiver cannot stall the block.
module radius_neighbor_count_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // Command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [rnc_pkg::CMD_W-1:0]          in_command,
  input  logic [rnc_pkg::COORD_BITS-1:0]     in_coord_x,
  input  logic [rnc_pkg::COORD_BITS-1:0]     in_coord_y,
  input  logic [rnc_pkg::COORD_BITS-1:0]     in_coord_z,
  // Result channel
  output logic                              out_valid,
  output logic [rnc_pkg::COUNT_W-1:0]        out_neighbor_count,
  output logic                              out_status,
  // Configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rnc_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [rnc_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rnc_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                              pready
);
  import rnc_pkg::*;

  logic [RADIUS_W-1:0] radius_r;
  logic                cfg_wr;
  logic                q_valid;
  logic                q_pop;
  q_item_t             q_item;

  // Configuration register: written on the access phase of an APB transfer
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr == REG_RADIUS_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
    end else if (cfg_wr) begin
      radius_r <= pwdata[RADIUS_W-1:0];
    end
  end

  assign prdata = (paddr == REG_RADIUS_ADDR) ? CFG_DATA_W'(radius_r) : '0;

  // Command intake and queue
  rnc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_coord_x (in_coord_x),
    .in_coord_y (in_coord_y),
    .in_coord_z (in_coord_z),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop)
  );

  // Execution and particle store
  rnc_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .radius_squared     (radius_r),
    .out_valid          (out_valid),
    .out_neighbor_count (out_neighbor_count),
    .out_status         (out_status)
  );

endmodule
